FILE: rtl/bia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, codes and types of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

    // Identifier and bitmap word geometry.
    localparam int ID_W          = 10;
    localparam int N_W           = ID_W + 1;
    localparam int WORD_BITS     = 32;
    localparam int BIT_W         = 5;
    localparam int MAP_DEPTH_DEF = 1024;

    // Register reset values.
    localparam logic [ID_W-1:0] MIN_ID_RST = 10'd100;
    localparam logic [ID_W-1:0] MAX_ID_RST = 10'd1000;

    // Register indexes on the configuration port.
    localparam logic REG_MIN_ID = 1'b0;
    localparam logic REG_MAX_ID = 1'b1;

    // Request kinds.
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_GRANTED      = 2'd0;
    localparam logic [1:0] ST_NONE_FREE    = 2'd1;
    localparam logic [1:0] ST_RELEASED     = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    // Outcome of the first-free search over one bitmap word.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_find;

endpackage

`default_nettype wire

FILE: rtl/bia_map_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_map_mem
// Usage bitmap storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_map_mem #(
    parameter int WORDS = 32,
    parameter int AW    = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [bia_pkg::WORD_BITS-1:0] i_wdata,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [bia_pkg::WORD_BITS-1:0] o_rdata
);
    import bia_pkg::*;

    logic [WORD_BITS-1:0] r_mem [WORDS];

    // Synchronous write; read data is registered and appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bia_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_find
// Priority search for the lowest free, in-range bit of one bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_find (
    input  wire logic [bia_pkg::WORD_BITS-1:0] i_word,
    input  wire logic [bia_pkg::WORD_BITS-1:0] i_valid,
    output bia_pkg::t_find                     o_res
);
    import bia_pkg::*;

    // Walk from the top down so that the lowest free bit wins.
    always_comb begin
        o_res = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b] && i_valid[b]) begin
                o_res.found = 1'b1;
                o_res.idx   = BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ctrl
// Sequencer that clears, scans and read-modify-writes the usage bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ctrl #(
    parameter int MAP_DEPTH = bia_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_kind,
    input  wire logic [bia_pkg::ID_W-1:0] i_release_id,
    input  wire logic [bia_pkg::ID_W-1:0] i_min_id,
    input  wire logic [bia_pkg::ID_W-1:0] i_max_id,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic      [bia_pkg::ID_W-1:0] o_granted_id,
    output logic      [1:0]               o_status
);
    import bia_pkg::*;

    localparam int WORDS = (MAP_DEPTH + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = AW + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_REL   = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_waddr, n_waddr;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic                 r_valid, n_valid;
    logic [ID_W-1:0]      r_granted, n_granted;
    logic [1:0]           r_status, n_status;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [N_W-1:0]       span;
    logic [N_W-1:0]       n_entries;
    logic [31:0]          base;
    logic [31:0]          rem;
    logic [31:0]          next_base;
    logic [WORD_BITS-1:0] bit_valid;
    logic [ID_W-1:0]      rel_off;
    logic                 rel_ok;
    logic [CW-1:0]        waddr_inc;
    t_find                find;

    // Number of bitmap entries covered by the configured range.
    always_comb begin
        if (i_max_id >= i_min_id) begin
            span = N_W'(i_max_id) - N_W'(i_min_id) + N_W'(1);
        end else begin
            span = '0;
        end
        if (32'(span) > 32'(MAP_DEPTH)) begin
            n_entries = N_W'(MAP_DEPTH);
        end else begin
            n_entries = span;
        end
    end

    // Word position of the scan and the in-range bits of the current word.
    assign base      = 32'(r_waddr) << BIT_W;
    assign next_base = base + 32'(WORD_BITS);
    assign rem       = 32'(n_entries) - base;
    assign waddr_inc = r_waddr + CW'(1);

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            bit_valid[b] = (32'(b) < rem);
        end
    end

    // Release range check relative to the current lower bound.
    assign rel_off = i_release_id - i_min_id;
    assign rel_ok  = (i_release_id >= i_min_id) && (i_release_id <= i_max_id) &&
                     (N_W'(rel_off) < n_entries);

    bia_find u_find (
        .i_word  (mem_rdata),
        .i_valid (bit_valid),
        .o_res   (find)
    );

    bia_map_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Next-state, memory access and result logic.
    always_comb begin
        n_state   = r_state;
        n_waddr   = r_waddr;
        n_bit     = r_bit;
        n_valid   = 1'b0;
        n_granted = r_granted;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_waddr[AW-1:0];
        mem_wdata = '0;
        mem_raddr = r_waddr[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_waddr == CW'(WORDS - 1)) begin
                    n_waddr = '0;
                    n_state = S_IDLE;
                end else begin
                    n_waddr = waddr_inc;
                end
            end
            S_IDLE: begin
                if (i_kind == KIND_ALLOC) begin
                    mem_raddr = '0;
                end else begin
                    mem_raddr = AW'(32'(rel_off) >> BIT_W);
                end
                if (i_start) begin
                    if (i_kind == KIND_ALLOC) begin
                        if (n_entries == '0) begin
                            n_valid   = 1'b1;
                            n_granted = '0;
                            n_status  = ST_NONE_FREE;
                        end else begin
                            n_waddr = '0;
                            n_state = S_SCAN;
                        end
                    end else if (rel_ok) begin
                        n_waddr = CW'(32'(rel_off) >> BIT_W);
                        n_bit   = rel_off[BIT_W-1:0];
                        n_state = S_REL;
                    end else begin
                        n_valid   = 1'b1;
                        n_granted = '0;
                        n_status  = ST_OUT_OF_RANGE;
                    end
                end
            end
            S_SCAN: begin
                // The next word is fetched while the current one is examined.
                mem_raddr = waddr_inc[AW-1:0];
                if (find.found) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | (WORD_BITS'(1) << find.idx);
                    n_valid   = 1'b1;
                    n_granted = ID_W'(32'(i_min_id) + base + 32'(find.idx));
                    n_status  = ST_GRANTED;
                    n_state   = S_IDLE;
                end else if (next_base >= 32'(n_entries)) begin
                    n_valid   = 1'b1;
                    n_granted = '0;
                    n_status  = ST_NONE_FREE;
                    n_state   = S_IDLE;
                end else begin
                    n_waddr = waddr_inc;
                end
            end
            S_REL: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~(WORD_BITS'(1) << r_bit);
                n_valid   = 1'b1;
                n_granted = '0;
                n_status  = ST_RELEASED;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; result payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_waddr <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_waddr <= n_waddr;
            r_valid <= n_valid;
        end
        r_bit     <= n_bit;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_granted_id = r_granted;
    assign o_status     = r_status;

endmodule

`default_nettype wire

FILE: rtl/bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Lowest-free identifier allocator over a usage bitmap held in block memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on o_granted_id and o_status for exactly one cycle with o_valid, and
// the receiver cannot stall it. The bitmap is stored as 32-bit words in a
// memory with a registered read. An allocate scans one word per cycle from
// the bottom of the range until it finds a free entry or passes the end of
// the range; a release is a read-modify-write of one word; an out-of-range
// release or an allocate on an empty range is answered straight from the
// idle state. After reset the block clears the memory one word per cycle,
// with busy held high. Configuration writes take effect at once and are meant
// for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator #(
    parameter int MAP_DEPTH = bia_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_kind,
    input  wire logic [bia_pkg::ID_W-1:0] i_release_id,
    output logic                          o_valid,
    output logic      [bia_pkg::ID_W-1:0] o_granted_id,
    output logic      [1:0]               o_status,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [bia_pkg::ID_W-1:0] i_cfg_data
);
    import bia_pkg::*;

    logic [ID_W-1:0] r_min_id;
    logic [ID_W-1:0] r_max_id;

    // Range registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_id <= MIN_ID_RST;
            r_max_id <= MAX_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_ID: r_min_id <= i_cfg_data;
                REG_MAX_ID: r_max_id <= i_cfg_data;
                default:    r_min_id <= r_min_id;
            endcase
        end
    end

    // Bitmap sequencer with its memory.
    bia_ctrl #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_release_id (i_release_id),
        .i_min_id     (r_min_id),
        .i_max_id     (r_max_id),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

FILE: tb/bia_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_result_checker
// Watches the request, result and configuration ports of the bitmap
// identifier allocator. It keeps its own usage bitmap and range registers,
// predicts the result of every accepted request, and compares each result
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_result_checker #(
    parameter int MAP_DEPTH = bia_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_busy,
    input  wire logic                     i_kind,
    input  wire logic [bia_pkg::ID_W-1:0] i_release_id,
    input  wire logic                     i_valid,
    input  wire logic [bia_pkg::ID_W-1:0] i_granted_id,
    input  wire logic [1:0]               i_status,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [bia_pkg::ID_W-1:0] i_cfg_data,
    output int                            o_errors,
    output int                            o_outstanding,
    output int                            o_granted,
    output int                            o_exhausted,
    output int                            o_released,
    output int                            o_rejected
);
    import bia_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [1:0]      st;
    } t_answer;

    // Model state: usage bitmap and the two range registers.
    logic            in_use [MAP_DEPTH];
    logic [ID_W-1:0] lo_id;
    logic [ID_W-1:0] hi_id;
    t_answer         answers_due [$];

    int errors;
    int n_granted;
    int n_exhausted;
    int n_released;
    int n_rejected;

    initial begin
        errors      = 0;
        n_granted   = 0;
        n_exhausted = 0;
        n_released  = 0;
        n_rejected  = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: mismatch: %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    // Applies one request to the model bitmap and returns its answer.
    task automatic serve_request(input logic kind, input logic [ID_W-1:0] rel,
                                 output t_answer ans);
        int span;
        int j;
        bit hit;
        span = (hi_id < lo_id) ? 0 : int'(hi_id) - int'(lo_id) + 1;
        if (span > MAP_DEPTH) begin
            span = MAP_DEPTH;
        end
        ans.id = '0;
        hit    = 1'b0;
        if (kind == KIND_ALLOC) begin
            ans.st = ST_NONE_FREE;
            for (j = 0; j < span && !hit; j++) begin
                if (!in_use[j]) begin
                    in_use[j] = 1'b1;
                    ans.id    = ID_W'(int'(lo_id) + j);
                    ans.st    = ST_GRANTED;
                    hit       = 1'b1;
                end
            end
        end else if (rel < lo_id || rel > hi_id || int'(rel - lo_id) >= span) begin
            ans.st = ST_OUT_OF_RANGE;
        end else begin
            in_use[int'(rel - lo_id)] = 1'b0;
            ans.st = ST_RELEASED;
        end
    endtask

    // Compare results first, then take register writes and new requests;
    // a request never completes in the cycle it is accepted.
    always @(posedge i_clk) begin : watch
        t_answer want;
        t_answer fresh;
        if (!i_rst_n) begin
            foreach (in_use[k]) begin
                in_use[k] = 1'b0;
            end
            lo_id = MIN_ID_RST;
            hi_id = MAX_ID_RST;
            answers_due.delete();
        end else begin
            if (i_valid) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result with no transaction outstanding, status",
                                    -1, int'(i_status));
                end else begin
                    want = answers_due.pop_front();
                    if (i_status != want.st) begin
                        report_mismatch("status", int'(want.st), int'(i_status));
                    end
                    if (i_granted_id != want.id) begin
                        report_mismatch("granted id", int'(want.id), int'(i_granted_id));
                    end
                    case (want.st)
                        ST_GRANTED:   n_granted++;
                        ST_NONE_FREE: n_exhausted++;
                        ST_RELEASED:  n_released++;
                        default:      n_rejected++;
                    endcase
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MIN_ID) begin
                    lo_id = i_cfg_data;
                end else begin
                    hi_id = i_cfg_data;
                end
            end
            if (i_start && !i_busy) begin
                serve_request(i_kind, i_release_id, fresh);
                answers_due.push_back(fresh);
            end
        end
        o_errors      <= errors;
        o_outstanding <= answers_due.size();
        o_granted     <= n_granted;
        o_exhausted   <= n_exhausted;
        o_released    <= n_released;
        o_rejected    <= n_rejected;
    end

endmodule

`default_nettype wire

FILE: tb/tb_bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_id_allocator
// Drives allocate and release requests into the identifier allocator under
// a series of range settings, with random idle gaps, and leaves prediction
// and comparison to the checker beside it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_id_allocator;
    import bia_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 25;
    localparam int PHASE_ITEMS = 50;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic            i_kind;
    logic [ID_W-1:0] i_release_id;
    logic            o_valid;
    logic [ID_W-1:0] o_granted_id;
    logic [1:0]      o_status;
    logic            i_cfg_we;
    logic            i_cfg_idx;
    logic [ID_W-1:0] i_cfg_data;

    int errors;
    int outstanding;
    int n_granted;
    int n_exhausted;
    int n_released;
    int n_rejected;
    int cycles;
    bit idle_on;
    int lo;
    int hi;

    bitmap_id_allocator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_release_id (i_release_id),
        .o_valid      (o_valid),
        .o_granted_id (o_granted_id),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    bia_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_kind        (i_kind),
        .i_release_id  (i_release_id),
        .i_valid       (o_valid),
        .i_granted_id  (o_granted_id),
        .i_status      (o_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_granted     (n_granted),
        .o_exhausted   (n_exhausted),
        .o_released    (n_released),
        .o_rejected    (n_rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, outstanding);
            $display("tb_bitmap_id_allocator: errors");
            $finish;
        end
    end

    // Presents one request and returns at the edge that accepts it.
    task automatic issue(input logic kind, input logic [ID_W-1:0] rel);
        if (idle_on && $urandom_range(99) < 35) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= kind;
        i_release_id <= rel;
        do @(posedge i_clk); while (busy);
    endtask

    // Holds off new requests until every result is back and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 || busy) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Sets both range registers while the block is idle.
    task automatic write_range(input int new_lo, input int new_hi);
        drain();
        lo         = new_lo;
        hi         = new_hi;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MIN_ID;
        i_cfg_data <= ID_W'(new_lo);
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAX_ID;
        i_cfg_data <= ID_W'(new_hi);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly identifiers in or just past the range, some anywhere at all.
    function automatic logic [ID_W-1:0] pick_release_id();
        int r;
        int span;
        r    = $urandom_range(99);
        span = (hi >= lo) ? hi - lo : 2;
        if (r < 70) begin
            return ID_W'(lo + $urandom_range(0, span + 1));
        end else if (r < 85) begin
            return ID_W'($urandom_range(0, 1023));
        end else if (r[0]) begin
            return ID_W'(lo - 1);
        end else begin
            return ID_W'(hi + 1);
        end
    endfunction

    initial begin : stimulus
        int ph;
        int n;
        int alloc_pct;
        start        <= 1'b0;
        i_kind       <= KIND_ALLOC;
        i_release_id <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_MIN_ID;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        idle_on      = 1'b1;
        lo           = int'(MIN_ID_RST);
        hi           = int'(MAX_ID_RST);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its bitmap after reset with busy held high.
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Reset range: grants from the bottom, reuse of a freed entry,
        // releases at and just past both ends, release of a free entry.
        issue(KIND_ALLOC, '0);
        issue(KIND_ALLOC, '1);
        issue(KIND_RELEASE, ID_W'(100));
        issue(KIND_ALLOC, '0);
        issue(KIND_RELEASE, ID_W'(99));
        issue(KIND_RELEASE, ID_W'(1001));
        issue(KIND_RELEASE, ID_W'(1000));
        issue(KIND_RELEASE, '0);
        issue(KIND_RELEASE, '1);

        // Small range over a bitmap left from the old range, run until full.
        write_range(5, 7);
        repeat (4) issue(KIND_ALLOC, '0);
        issue(KIND_RELEASE, ID_W'(4));
        issue(KIND_RELEASE, ID_W'(8));
        issue(KIND_RELEASE, ID_W'(5));
        issue(KIND_ALLOC, '0);

        // Empty range: nothing to grant, nothing to release.
        write_range(20, 10);
        issue(KIND_ALLOC, '0);
        issue(KIND_RELEASE, ID_W'(15));
        issue(KIND_RELEASE, ID_W'(20));

        // Whole identifier space, then a single top identifier.
        write_range(0, 1023);
        issue(KIND_RELEASE, '1);
        issue(KIND_ALLOC, '1);
        write_range(1023, 1023);
        issue(KIND_ALLOC, '0);
        issue(KIND_ALLOC, '0);
        issue(KIND_RELEASE, '1);

        // Random phases, each under a fresh range setting. Small ranges
        // dominate so that the map fills and drains often.
        for (ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(9))
                0: begin
                    lo = $urandom_range(1, 1023);
                    hi = $urandom_range(0, lo - 1);
                end
                1: begin
                    lo = 0;
                    hi = 1023;
                end
                2: begin
                    lo = $urandom_range(0, 1023);
                    hi = 1023;
                end
                3: begin
                    lo = 0;
                    hi = $urandom_range(0, 40);
                end
                default: begin
                    lo = $urandom_range(0, 1023);
                    hi = lo + $urandom_range(0, 47);
                    if (hi > 1023) begin
                        hi = 1023;
                    end
                end
            endcase
            write_range(lo, hi);
            idle_on   = !(ph >= 6 && ph < 10);
            alloc_pct = $urandom_range(35, 75);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && $urandom_range(3) == 0) begin
                    drain();
                end
                if ($urandom_range(99) < alloc_pct) begin
                    issue(KIND_ALLOC, ID_W'($urandom));
                end else begin
                    issue(KIND_RELEASE, pick_release_id());
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);

        $display("checked %0d results: %0d grants, %0d map-full answers,",
                 n_granted + n_exhausted + n_released + n_rejected,
                 n_granted, n_exhausted);
        $display("%0d releases and %0d out-of-range rejects over %0d range settings",
                 n_released, n_rejected, PHASES + 4);
        if (errors == 0) begin
            $display("tb_bitmap_id_allocator: clean");
        end else begin
            $display("tb_bitmap_id_allocator: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
